### src/aescbc_pkg.sv
// aescbc_pkg: shared constants and functions for the aes-128 cbc encryptor
// byte order: byte 0 is bits 127:120 of a 128-bit word
// no dependencies
package aescbc_pkg;

	localparam int unsigned BlockW  = 128;
	localparam int unsigned HalfW   = 64;
	localparam int unsigned Rounds  = 10;
	localparam int unsigned RndW    = 4;
	localparam int unsigned CfgIdxW = 2;

	typedef logic [BlockW-1:0] block_t;
	typedef logic [RndW-1:0]   rnd_t;

	// register indexes of the configuration port
	typedef enum logic [CfgIdxW-1:0] {
		REG_KEY_HIGH = 2'd0,
		REG_KEY_LOW  = 2'd1,
		REG_IV_HIGH  = 2'd2,
		REG_IV_LOW   = 2'd3
	} cfg_reg_t;

	// forward s-box
	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] r;
		unique case (a)
			8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
			8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
			8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
			8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
			8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
			8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
			8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
			8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
			8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
			8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
			8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
			8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
			8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
			8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
			8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
			8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
			8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
			8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
			8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
			8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
			8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
			8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
			8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
			8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
			8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
			8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
			8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
			8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
			8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
			8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
			8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
			8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
			8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
			8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
			8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
			8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
			8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
			8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
			8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
			8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
			8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
			8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
			8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
			8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
			8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
			8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
			8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
			8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
			8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
			8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
			8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
			8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
			8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
			8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
			8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
			8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
			8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
			8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
			8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
			8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
			8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
			8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
			8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
			8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
			default: r=8'h00;
		endcase
		return r;
	endfunction

	// round constant for expansion step i (1..10)
	function automatic logic [7:0] rcon(input rnd_t i);
		logic [7:0] r;
		unique case (i)
			4'd1: r = 8'h01;
			4'd2: r = 8'h02;
			4'd3: r = 8'h04;
			4'd4: r = 8'h08;
			4'd5: r = 8'h10;
			4'd6: r = 8'h20;
			4'd7: r = 8'h40;
			4'd8: r = 8'h80;
			4'd9: r = 8'h1b;
			4'd10: r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// next round key from the previous one
	function automatic block_t next_rk(input block_t rk, input rnd_t i);
		logic [31:0] w0, w1, w2, w3, t;
		block_t n;
		w0 = rk[127:96];
		w1 = rk[95:64];
		w2 = rk[63:32];
		w3 = rk[31:0];
		t = {sbox(w3[23:16]) ^ rcon(i), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
		n[127:96] = w0 ^ t;
		n[95:64]  = w1 ^ n[127:96];
		n[63:32]  = w2 ^ n[95:64];
		n[31:0]   = w3 ^ n[63:32];
		return n;
	endfunction

endpackage

### src/aescbc_if.sv
// aescbc interfaces: valid/ready channels for input, output and configuration
// depends on aescbc_pkg for widths
interface aescbc_in_if;
	logic                       valid;
	logic                       ready;
	logic [aescbc_pkg::HalfW-1:0] plain_high;
	logic [aescbc_pkg::HalfW-1:0] plain_low;
	logic                       new_message;
	modport source (output valid, plain_high, plain_low, new_message, input ready);
	modport sink (input valid, plain_high, plain_low, new_message, output ready);
endinterface

interface aescbc_out_if;
	logic                       valid;
	logic                       ready;
	logic [aescbc_pkg::HalfW-1:0] cipher_high;
	logic [aescbc_pkg::HalfW-1:0] cipher_low;
	modport source (output valid, cipher_high, cipher_low, input ready);
	modport sink (input valid, cipher_high, cipher_low, output ready);
endinterface

interface aescbc_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [aescbc_pkg::CfgIdxW-1:0] index;
	logic [aescbc_pkg::HalfW-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### src/aescbc_round.sv
// aescbc_round: one aes encryption round (subbytes, shiftrows, mixcolumns, addroundkey)
// depends on aescbc_pkg
module aescbc_round (
	input  aescbc_pkg::block_t st,
	input  aescbc_pkg::block_t rk,
	input  logic               last,
	output aescbc_pkg::block_t nxt
);
	import aescbc_pkg::*;

	logic [7:0] sb [16];
	logic [7:0] mc [16];
	block_t     sh;
	block_t     mx;

	// substitute and shift rows
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				sb[r + 4*c] = sbox(st[127 - 8*(r + 4*((c + r) % 4)) -: 8]);
			end
		end
		for (int k = 0; k < 16; k++) begin
			sh[127 - 8*k -: 8] = sb[k];
		end
	end

	// mix columns
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			logic [7:0] a0, a1, a2, a3, al, x0, x1, x2, x3;
			a0 = sb[4*c]; a1 = sb[4*c+1]; a2 = sb[4*c+2]; a3 = sb[4*c+3];
			al = a0 ^ a1 ^ a2 ^ a3;
			x0 = a0 ^ a1; x1 = a1 ^ a2; x2 = a2 ^ a3; x3 = a3 ^ a0;
			mc[4*c]   = a0 ^ al ^ {x0[6:0], 1'b0} ^ (x0[7] ? 8'h1b : 8'h00);
			mc[4*c+1] = a1 ^ al ^ {x1[6:0], 1'b0} ^ (x1[7] ? 8'h1b : 8'h00);
			mc[4*c+2] = a2 ^ al ^ {x2[6:0], 1'b0} ^ (x2[7] ? 8'h1b : 8'h00);
			mc[4*c+3] = a3 ^ al ^ {x3[6:0], 1'b0} ^ (x3[7] ? 8'h1b : 8'h00);
		end
		for (int k = 0; k < 16; k++) begin
			mx[127 - 8*k -: 8] = mc[k];
		end
	end

	// final round skips mix columns
	assign nxt = (last ? sh : mx) ^ rk;

endmodule

### src/aes128_cbc_encrypt.sv
// channel  | dir | fields                               | accepted when
// in_ch    | in  | plain_high, plain_low, new_message   | in_ch.valid & in_ch.ready
// out_ch   | out | cipher_high, cipher_low              | out_ch.valid & out_ch.ready
// cfg_ch   | in  | index, data                          | cfg_ch.valid & cfg_ch.ready
//
// a block is the whitening key add at request plus ten rounds, one round per cycle
// unless stalled, through a single round unit fed by the round key memory.
// after reset and after each key write the key schedule fills the memory, and
// no request is taken until it is done. a result held in the output
// register while the next block finishes stalls that block on its last round.
// depends on aescbc_pkg, aescbc_if.sv and aescbc_round
module aes128_cbc_encrypt (
	input  logic                clk,
	input  logic                arst_n,
	aescbc_in_if.sink           in_ch,
	aescbc_out_if.source        out_ch,
	aescbc_cfg_if.sink          cfg_ch
);
	import aescbc_pkg::*;

	typedef enum logic [1:0] {ST_EXPAND, ST_IDLE, ST_RUN} fsm_t;

	fsm_t               state_q;
	rnd_t               cnt_q;
	logic [HalfW-1:0]   key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
	block_t             chain_q;
	block_t             blk_q;
	block_t             rk_q;
	block_t             out_q;
	logic               out_valid_q;

	// round key memory
	block_t             rk_mem [Rounds+1];
	block_t             rd_q;
	rnd_t               raddr;
	logic               mem_we;
	block_t             mem_wd;

	block_t             rnd_out;
	block_t             rk_next;
	logic               last_rnd;
	logic               finish;
	logic               in_acc;
	logic               key_wr;
	block_t             chain_in;

	assign cfg_ch.ready = 1'b1;
	assign key_wr = cfg_ch.valid && (cfg_ch.index == REG_KEY_HIGH || cfg_ch.index == REG_KEY_LOW);
	assign in_ch.ready = (state_q == ST_IDLE) && !key_wr;
	assign in_acc = in_ch.valid && in_ch.ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.cipher_high = out_q[127:64];
	assign out_ch.cipher_low = out_q[63:0];

	assign last_rnd = (cnt_q == rnd_t'(Rounds));
	assign finish = (state_q == ST_RUN) && last_rnd && (!out_valid_q || out_ch.ready);
	assign chain_in = in_ch.new_message ? {iv_hi_q, iv_lo_q} : chain_q;

	// key schedule step and memory write
	assign rk_next = next_rk(rk_q, cnt_q);
	always_comb begin
		mem_we = (state_q == ST_EXPAND);
		mem_wd = (cnt_q == '0) ? {key_hi_q, key_lo_q} : rk_next;
	end

	// read address: round ahead in run, held on stall, 1 on accept, else 0
	always_comb begin
		priority if (state_q == ST_RUN && !last_rnd) begin
			raddr = cnt_q + rnd_t'(1);
		end else if (state_q == ST_RUN && !finish) begin
			raddr = cnt_q;
		end else if (in_acc) begin
			raddr = rnd_t'(1);
		end else begin
			raddr = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			rk_mem[cnt_q] <= mem_wd;
		end
		rd_q <= rk_mem[raddr];
	end

	aescbc_round u_round (
		.st   (blk_q),
		.rk   (rd_q),
		.last (last_rnd),
		.nxt  (rnd_out)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
			iv_hi_q  <= '0;
			iv_lo_q  <= '0;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				REG_KEY_HIGH: key_hi_q <= cfg_ch.data;
				REG_KEY_LOW:  key_lo_q <= cfg_ch.data;
				REG_IV_HIGH:  iv_hi_q  <= cfg_ch.data;
				REG_IV_LOW:   iv_lo_q  <= cfg_ch.data;
				default: ;
			endcase
		end
	end

	// sequencer: key expansion, rounds, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_EXPAND;
			cnt_q       <= '0;
			chain_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_EXPAND: begin
					rk_q <= mem_wd;
					if (cnt_q == rnd_t'(Rounds)) begin
						state_q <= ST_IDLE;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + rnd_t'(1);
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						blk_q   <= {in_ch.plain_high, in_ch.plain_low} ^ chain_in ^ rd_q;
						cnt_q   <= rnd_t'(1);
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (!last_rnd) begin
						blk_q <= rnd_out;
						cnt_q <= cnt_q + rnd_t'(1);
					end else if (finish) begin
						out_q       <= rnd_out;
						chain_q     <= rnd_out;
						out_valid_q <= 1'b1;
						cnt_q       <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// key change restarts the schedule
			if (key_wr) begin
				state_q <= ST_EXPAND;
				cnt_q   <= '0;
			end
		end
	end

endmodule
